/* design/chm_pkg.sv */
// chm_pkg: shared widths, codes and defaults of the chained hash member map
// no dependencies; compiled first
`default_nettype none

package chm_pkg;

    // fixed field widths of the channels
    localparam int KEY_WIDTH      = 32;
    localparam int REF_PORT_WIDTH = 8;
    localparam int STATUS_WIDTH   = 2;
    localparam int COUNT_WIDTH    = 5;

    // bucket count after reset
    localparam int COUNT_RESET = 16;

    // modulo unit: key bits retired per cycle
    localparam int DIGIT_BITS = 4;
    localparam int DIV_STEPS  = KEY_WIDTH / DIGIT_BITS;
    localparam int STEP_WIDTH = $clog2(DIV_STEPS);

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // parameter defaults
    localparam int DEF_NUM_BUCKETS  = 16;
    localparam int DEF_BUCKET_DEPTH = 8;
    localparam int DEF_REF_WIDTH    = 8;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // result status codes
    localparam logic [STATUS_WIDTH-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_FOUND    = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_MISSING  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL     = 2'd3;

endpackage

`default_nettype wire

/* design/chm_req_if.sv */
// chm_req_if: request channel (insert or lookup word)
// depends on chm_pkg
`default_nettype none

interface chm_req_if
    import chm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [KEY_WIDTH-1:0]      key_hash;
    logic [REF_PORT_WIDTH-1:0] member_ref;

    modport source (output valid, output command, output key_hash, output member_ref,
                    input ready);
    modport sink   (input valid, input command, input key_hash, input member_ref,
                    output ready);
endinterface

`default_nettype wire

/* design/chm_rsp_if.sv */
// chm_rsp_if: result channel (status and found reference)
// depends on chm_pkg
`default_nettype none

interface chm_rsp_if
    import chm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_WIDTH-1:0]   status;
    logic [REF_PORT_WIDTH-1:0] found_ref;

    modport source (output valid, output status, output found_ref, input ready);
    modport sink   (input valid, input status, input found_ref, output ready);
endinterface

`default_nettype wire

/* design/chm_cfg_if.sv */
// chm_cfg_if: configuration write channel for the bucket count register
// depends on chm_pkg
`default_nettype none

interface chm_cfg_if
    import chm_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/chm_front.sv */
// chm_front: accepts request words, reduces the key hash modulo the bucket count
// depends on chm_pkg, chm_req_if, chm_cfg_if
`default_nettype none

module chm_front
    import chm_pkg::*;
#(
    parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
    parameter int REF_WIDTH   = DEF_REF_WIDTH,
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
    localparam int RK = (REF_WIDTH < REF_PORT_WIDTH) ? REF_WIDTH : REF_PORT_WIDTH,
    localparam int QW = 1 + KEY_WIDTH + RK + BW
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    chm_req_if.sink            req,
    chm_cfg_if.sink            cfg,
    output logic               push_valid,
    input  wire logic          push_ready,
    output logic [QW-1:0]      push_data
);

    localparam int CountMax = (NUM_BUCKETS < (2**COUNT_WIDTH - 1)) ?
                              NUM_BUCKETS : (2**COUNT_WIDTH - 1);
    localparam int CountInit = (COUNT_RESET < CountMax) ? COUNT_RESET : CountMax;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [STEP_WIDTH-1:0]  step_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [COUNT_WIDTH-1:0] rem_next;
    logic [KEY_WIDTH-1:0]   shift_reg;
    logic                   cmd_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [RK-1:0]          ref_reg;
    logic                   req_take;

    assign req.ready  = (state_reg == F_IDLE);
    assign cfg.ready  = 1'b1;
    assign req_take   = req.valid && req.ready;
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = {cmd_reg, key_reg, ref_reg, BW'(rem_reg)};

    // saturate the written count into 1..CountMax
    always_comb
    begin
        if (cfg.data == '0)
        begin
            count_next = COUNT_WIDTH'(1);
        end
        else if (int'(cfg.data) > CountMax)
        begin
            count_next = COUNT_WIDTH'(CountMax);
        end
        else
        begin
            count_next = cfg.data;
        end
    end

    // one radix-16 digit of restoring remainder per cycle
    always_comb
    begin
        logic [COUNT_WIDTH:0]   trial;
        logic [COUNT_WIDTH-1:0] rem_v;
        rem_v = rem_reg;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            trial = {rem_v, shift_reg[KEY_WIDTH-1-i]};
            if (trial >= {1'b0, count_reg})
            begin
                trial = trial - {1'b0, count_reg};
            end
            rem_v = trial[COUNT_WIDTH-1:0];
        end
        rem_next = rem_v;
    end

    // front sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (req_take)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (step_reg == STEP_WIDTH'(DIV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            count_reg <= COUNT_WIDTH'(CountInit);
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                count_reg <= count_next;
            end
            if (req_take)
            begin
                step_reg <= '0;
            end
            else if (state_reg == F_DIV)
            begin
                step_reg <= step_reg + STEP_WIDTH'(1);
            end
        end
    end

    // word and remainder datapath
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            cmd_reg   <= req.command;
            key_reg   <= req.key_hash;
            ref_reg   <= req.member_ref[RK-1:0];
            shift_reg <= req.key_hash;
            rem_reg   <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_reg << DIGIT_BITS;
        end
    end

endmodule

`default_nettype wire

/* design/chm_queue.sv */
// chm_queue: short first-in first-out queue between front and back
// depends on chm_pkg
`default_nettype none

module chm_queue
    import chm_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = data_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* design/chm_back.sv */
// chm_back: bucket store, insert and lookup scan, result register
// depends on chm_pkg, chm_rsp_if
`default_nettype none

module chm_back
    import chm_pkg::*;
#(
    parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS,
    parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH,
    parameter int REF_WIDTH    = DEF_REF_WIDTH,
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
    localparam int RK = (REF_WIDTH < REF_PORT_WIDTH) ? REF_WIDTH : REF_PORT_WIDTH,
    localparam int QW = 1 + KEY_WIDTH + RK + BW
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire logic [QW-1:0] q_data,
    chm_rsp_if.source          rsp
);

    localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW    = $clog2(BUCKET_DEPTH + 1);
    localparam int Slots = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int AW    = (Slots > 1) ? $clog2(Slots) : 1;
    localparam int EW    = KEY_WIDTH + RK;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_FILL = 2'd1;
    localparam logic [1:0] B_SCAN = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    logic [EW-1:0] entry_mem [Slots];
    logic [FW-1:0] fill_mem  [NUM_BUCKETS];

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    logic [NUM_BUCKETS-1:0]    fill_valid_reg;
    logic [FW-1:0]             fill_rd_reg;
    logic                      fill_vld_rd_reg;
    logic [EW-1:0]             entry_rd_reg;
    logic                      cmd_reg;
    logic [KEY_WIDTH-1:0]      key_reg;
    logic [RK-1:0]             ref_reg;
    logic [BW-1:0]             bucket_reg;
    logic [FW-1:0]             fill_reg;
    logic [SW-1:0]             slot_reg;
    logic [STATUS_WIDTH-1:0]   res_status_reg;
    logic [STATUS_WIDTH-1:0]   res_status_next;
    logic [REF_PORT_WIDTH-1:0] res_ref_reg;
    logic [REF_PORT_WIDTH-1:0] res_ref_next;
    logic                      out_valid_reg;
    logic [STATUS_WIDTH-1:0]   out_status_reg;
    logic [REF_PORT_WIDTH-1:0] out_ref_reg;

    logic [BW-1:0] q_bucket;
    logic          q_take;
    logic [FW-1:0] fill_cur;
    logic          bucket_full;
    logic          ins_ok;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [FW-1:0] slot_inc;
    logic [SW-1:0] slot_nxt;
    logic          hash_hit;
    logic          scan_last;
    logic          out_free;

    assign q_bucket    = q_data[BW-1:0];
    assign q_ready     = (state_reg == B_IDLE);
    assign q_take      = q_valid && q_ready;
    assign fill_cur    = fill_vld_rd_reg ? fill_rd_reg : '0;
    assign bucket_full = (fill_cur == FW'(BUCKET_DEPTH));
    assign ins_ok      = (state_reg == B_FILL) && (cmd_reg == CMD_INSERT) && !bucket_full;
    assign base_addr   = AW'(bucket_reg) * AW'(BUCKET_DEPTH);
    assign wr_addr     = base_addr + AW'(fill_cur);

    // next slot to read, kept inside the bucket
    assign slot_inc  = FW'(slot_reg) + FW'(1);
    assign slot_nxt  = (slot_inc == FW'(BUCKET_DEPTH)) ? '0 : SW'(slot_inc);
    assign rd_addr   = base_addr + AW'((state_reg == B_FILL) ? '0 : slot_nxt);
    assign hash_hit  = (entry_rd_reg[EW-1 -: KEY_WIDTH] == key_reg);
    assign scan_last = (slot_inc == fill_reg);

    assign out_free      = !out_valid_reg || rsp.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.found_ref = out_ref_reg;

    // back sequencer and result selection
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_ref_next    = res_ref_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_take)
                begin
                    state_next = B_FILL;
                end
            end
            B_FILL:
            begin
                res_ref_next = '0;
                if (cmd_reg == CMD_INSERT)
                begin
                    res_status_next = bucket_full ? ST_FULL : ST_INSERTED;
                    state_next      = B_DONE;
                end
                else if (fill_cur == '0)
                begin
                    res_status_next = ST_MISSING;
                    state_next      = B_DONE;
                end
                else
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (hash_hit)
                begin
                    res_status_next = ST_FOUND;
                    res_ref_next    = REF_PORT_WIDTH'(entry_rd_reg[RK-1:0]);
                    state_next      = B_DONE;
                end
                else if (scan_last)
                begin
                    res_status_next = ST_MISSING;
                    res_ref_next    = '0;
                    state_next      = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control registers and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            fill_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ins_ok)
            begin
                fill_valid_reg[bucket_reg] <= 1'b1;
            end
            if ((state_reg == B_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item, scan and result datapath
    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_ref_reg    <= res_ref_next;
        if (q_take)
        begin
            cmd_reg    <= q_data[QW-1];
            key_reg    <= q_data[QW-2 -: KEY_WIDTH];
            ref_reg    <= q_data[BW+RK-1 -: RK];
            bucket_reg <= q_bucket;
        end
        if (state_reg == B_FILL)
        begin
            fill_reg <= fill_cur;
            slot_reg <= '0;
        end
        else if (state_reg == B_SCAN)
        begin
            slot_reg <= slot_nxt;
        end
        if ((state_reg == B_DONE) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_ref_reg    <= res_ref_reg;
        end
    end

    // fill count memory, registered read
    always_ff @(posedge clk)
    begin
        if (ins_ok)
        begin
            fill_mem[bucket_reg] <= fill_cur + FW'(1);
        end
        fill_rd_reg     <= fill_mem[q_bucket];
        fill_vld_rd_reg <= fill_valid_reg[q_bucket];
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (ins_ok)
        begin
            entry_mem[wr_addr] <= {key_reg, ref_reg};
        end
        entry_rd_reg <= entry_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* design/chained_hash_member_map.sv */
// chained_hash_member_map: top level, front divider, queue and bucket back end
// depends on chm_pkg, chm_req_if, chm_rsp_if, chm_cfg_if, chm_front, chm_queue, chm_back
//
// Hash map with separate chaining and fixed bucket depth.
// req: one word per item; command 0 appends (key_hash, member_ref) to bucket
//   key_hash mod bucket_count, command 1 looks the key hash up in that bucket.
// rsp: one word per item, in order: status and, when found, the member reference.
// cfg: writes the bucket count (0 acts as 1, above NUM_BUCKETS saturates); write
//   only while no item is in flight. Always ready.
// Sequence: the front accepts a word, runs 8 radix-16 remainder steps and hands
//   the word off; the back then reads the bucket fill count and finishes an insert
//   or an empty-bucket lookup without a scan, or scans the bucket for a lookup,
//   one entry memory read per cycle.
// Overlap: the front and back overlap through a two-word queue, so the front can
//   take a new word while the back still works on older ones; long lookup scans
//   in the back then set the pace.
// Reset: bucket count 16, all buckets empty through per-bucket valid bits; no
//   clearing pass, the block is ready as soon as reset is released.
// A stalled rsp holds its word; the back parks one finished result behind it and
//   the front keeps filling the queue until it is full.
`default_nettype none

module chained_hash_member_map
    import chm_pkg::*;
#(
    parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS,
    parameter int BUCKET_DEPTH = DEF_BUCKET_DEPTH,
    parameter int REF_WIDTH    = DEF_REF_WIDTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    chm_req_if.sink   req,
    chm_rsp_if.source rsp,
    chm_cfg_if.sink   cfg
);

    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int RK = (REF_WIDTH < REF_PORT_WIDTH) ? REF_WIDTH : REF_PORT_WIDTH;
    localparam int QW = 1 + KEY_WIDTH + RK + BW;

    logic          push_valid;
    logic          push_ready;
    logic [QW-1:0] push_data;
    logic          q_valid;
    logic          q_ready;
    logic [QW-1:0] q_data;

    // request intake and bucket index
    chm_front #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .REF_WIDTH   (REF_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    chm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    // bucket store and scan
    chm_back #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .REF_WIDTH    (REF_WIDTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

/* dv/chained_hash_member_map_tb.sv */
`timescale 1ns / 100ps
// chained_hash_member_map_tb: self-checking bench for the chained hash member map
// depends on chm_pkg, chm_req_if, chm_rsp_if, chm_cfg_if and chained_hash_member_map

module chained_hash_member_map_tb;
    import chm_pkg::*;

    localparam int BUCKETS     = DEF_NUM_BUCKETS;
    localparam int DEPTH       = DEF_BUCKET_DEPTH;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 115;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0]   status;
        logic [REF_PORT_WIDTH-1:0] found_ref;
    } map_result_t;

    // one row of the directed table: a bucket count write or a request word
    typedef struct packed {
        logic                      is_cfg;
        logic [COUNT_WIDTH-1:0]    count;
        logic                      command;
        logic [KEY_WIDTH-1:0]      key_hash;
        logic [REF_PORT_WIDTH-1:0] member_ref;
        logic                      typed;
        map_result_t               result;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    chm_req_if req_ch ();
    chm_rsp_if rsp_ch ();
    chm_cfg_if cfg_ch ();

    chained_hash_member_map uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // model of the table contents
    logic [COUNT_WIDTH-1:0]    bucket_count_q;
    int unsigned               fill_count [BUCKETS];
    logic [KEY_WIDTH-1:0]      slot_hash  [BUCKETS*DEPTH];
    logic [REF_PORT_WIDTH-1:0] slot_ref   [BUCKETS*DEPTH];

    map_result_t          pending_results [$];
    logic [KEY_WIDTH-1:0] stored_keys [$];
    stim_row_t            directed_rows [$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 0;
    int unsigned ready_span     = 0;
    int unsigned ready_mode     = 0;

    logic [COUNT_WIDTH-1:0] phase_counts [0:5] = '{5'd3, 5'd1, 5'd16, 5'd0, 5'd31, 5'd17};

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[chained_hash_member_map] ERROR");
            $finish;
        end
    end

    // buckets in use: zero acts as one, large counts saturate
    function automatic int unsigned active_buckets();
        if (bucket_count_q == 0)
            return 1;
        if (bucket_count_q > BUCKETS)
            return BUCKETS;
        return 32'(bucket_count_q);
    endfunction

    // apply one word to the model table and return its result
    function automatic map_result_t hash_map_apply(logic cmd, logic [KEY_WIDTH-1:0] key,
                                                   logic [REF_PORT_WIDTH-1:0] mref);
        int unsigned bucket;
        int unsigned base;
        int unsigned fill;
        map_result_t res;
        bucket = key % active_buckets();
        base   = bucket * DEPTH;
        fill   = fill_count[bucket];
        res.status    = ST_MISSING;
        res.found_ref = '0;
        if (cmd == CMD_INSERT)
        begin
            if (fill >= DEPTH)
                res.status = ST_FULL;
            else
            begin
                slot_hash[base + fill] = key;
                slot_ref[base + fill]  = mref;
                fill_count[bucket]     = fill + 1;
                res.status             = ST_INSERTED;
            end
        end
        else
        begin
            // first match in insertion order wins
            for (int i = 0; i < fill; i++)
            begin
                if (res.status == ST_MISSING && slot_hash[base + i] == key)
                begin
                    res.status    = ST_FOUND;
                    res.found_ref = slot_ref[base + i];
                end
            end
        end
        return res;
    endfunction

    function automatic stim_row_t row_word(logic cmd, logic [KEY_WIDTH-1:0] key,
                                           logic [REF_PORT_WIDTH-1:0] mref, logic typed,
                                           logic [STATUS_WIDTH-1:0] status,
                                           logic [REF_PORT_WIDTH-1:0] found_ref);
        stim_row_t row;
        row.is_cfg           = 1'b0;
        row.count            = '0;
        row.command          = cmd;
        row.key_hash         = key;
        row.member_ref       = mref;
        row.typed            = typed;
        row.result.status    = status;
        row.result.found_ref = found_ref;
        return row;
    endfunction

    function automatic stim_row_t row_count(logic [COUNT_WIDTH-1:0] count);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.count  = count;
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    // put one request word on the channel and wait until it is taken
    task automatic send_word(logic cmd, logic [KEY_WIDTH-1:0] key,
                             logic [REF_PORT_WIDTH-1:0] mref, logic typed,
                             map_result_t typed_result);
        map_result_t res;
        req_ch.valid      <= 1'b1;
        req_ch.command    <= cmd;
        req_ch.key_hash   <= key;
        req_ch.member_ref <= mref;
        do
            @(posedge clk);
        while (!req_ch.ready);
        res = hash_map_apply(cmd, key, mref);
        if (res.status == ST_INSERTED)
        begin
            stored_keys.push_back(key);
            if (stored_keys.size() > 64)
                void'(stored_keys.pop_front());
        end
        pending_results.push_back(typed ? typed_result : res);
    endtask

    // bursts of back-to-back words with random gaps between them
    task automatic pace_sender();
        if (burst_left != 0)
            burst_left--;
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // write the bucket count once every word in flight has come back
    task automatic write_bucket_count(logic [COUNT_WIDTH-1:0] count);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= count;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid   <= 1'b0;
        bucket_count_q  = count;
    endtask

    // result ready: its own pattern, changing mode after a random span
    always @(posedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_span = $urandom_range(20, 80);
        end
        else
            ready_span = ready_span - 1;
        case (ready_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= 1'($urandom_range(0, 1));
            default: rsp_ch.ready <= (ready_span[3:0] == 4'd0);
        endcase
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        map_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result word", 32'(rsp_ch.status), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                if (rsp_ch.found_ref !== want.found_ref)
                    report_mismatch("found_ref", 32'(rsp_ch.found_ref),
                                    32'(want.found_ref));
            end
        end
    end

    initial
    begin
        logic                      cmd;
        logic [KEY_WIDTH-1:0]      key;
        logic [REF_PORT_WIDTH-1:0] mref;
        logic [COUNT_WIDTH-1:0]    count;
        int unsigned               pick;
        stim_row_t                 row;

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_INSERT;
        req_ch.key_hash   = '0;
        req_ch.member_ref = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;
        rsp_ch.ready      = 1'b0;

        bucket_count_q = COUNT_WIDTH'(COUNT_RESET);
        foreach (fill_count[i])
            fill_count[i] = 0;

        // directed table
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'h0000_0000, 8'hFF, 1, ST_MISSING, 8'h00));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1, ST_MISSING, 8'h00));
        directed_rows.push_back(row_word(CMD_INSERT, 32'h0000_0000, 8'h00, 1, ST_INSERTED, 8'h00));
        directed_rows.push_back(row_word(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 1, ST_INSERTED, 8'h00));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 1, ST_FOUND, 8'hFF));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'h0000_0000, 8'hFF, 1, ST_FOUND, 8'h00));
        // duplicate hash: the earlier entry is the one found
        directed_rows.push_back(row_word(CMD_INSERT, 32'd5, 8'h11, 1, ST_INSERTED, 8'h00));
        directed_rows.push_back(row_word(CMD_INSERT, 32'd5, 8'h22, 1, ST_INSERTED, 8'h00));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'd5, 8'h00, 1, ST_FOUND, 8'h11));
        // fill bucket five to the top, then overflow it
        for (int i = 1; i <= 6; i++)
            directed_rows.push_back(row_word(CMD_INSERT, 32'd5 + 16 * i,
                                             REF_PORT_WIDTH'(8'h30 + i), 0,
                                             ST_INSERTED, 8'h00));
        directed_rows.push_back(row_word(CMD_INSERT, 32'd117, 8'hA0, 1, ST_FULL, 8'h00));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'd117, 8'h00, 1, ST_MISSING, 8'h00));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'd101, 8'h00, 0, ST_MISSING, 8'h00));
        // zero count acts as one bucket
        directed_rows.push_back(row_count(5'd0));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'd5, 8'h00, 0, ST_MISSING, 8'h00));
        directed_rows.push_back(row_word(CMD_INSERT, 32'hA5A5_A5A5, 8'h5A, 0, ST_MISSING, 8'h00));
        // oversized count saturates
        directed_rows.push_back(row_count(5'd31));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00, 0, ST_MISSING, 8'h00));
        // entry left behind under an older modulus
        directed_rows.push_back(row_count(5'd16));
        directed_rows.push_back(row_word(CMD_LOOKUP, 32'hA5A5_A5A5, 8'h00, 0, ST_MISSING, 8'h00));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
                write_bucket_count(row.count);
            else
            begin
                send_word(row.command, row.key_hash, row.member_ref, row.typed, row.result);
                pace_sender();
            end
        end

        // random phases, each under its own bucket count
        for (int p = 0; p < PHASES; p++)
        begin
            count = (p < 6) ? phase_counts[p] : COUNT_WIDTH'($urandom_range(0, 31));
            write_bucket_count(count);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                cmd  = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
                mref = REF_PORT_WIDTH'($urandom);
                pick = $urandom_range(0, 99);
                key  = $urandom;
                if (stored_keys.size() != 0)
                begin
                    // mostly keys already stored, or keys sharing their bucket
                    if ((cmd == CMD_LOOKUP && pick < 60) || (cmd == CMD_INSERT && pick < 20))
                        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                    else if (pick < 80)
                        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)]
                              + active_buckets() * $urandom_range(1, 1000);
                    else if (cmd == CMD_INSERT && pick < 90)
                        key = $urandom_range(0, 63);
                end
                send_word(cmd, key, mref, 1'b0, '0);
                pace_sender();
            end
        end

        // drain
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("[chained_hash_member_map] OK");
        else
            $display("[chained_hash_member_map] ERROR");
        $finish;
    end

endmodule
